// ----- rtl/arnf_pkg.sv -----
// ----------------------------------------------------------------------------
// arnf_pkg
// Shared widths, register codes and sequencer states of the autoregressive
// noise filter.
// ----------------------------------------------------------------------------
package arnf_pkg;

    // Field widths
    localparam int ELEM_W     = 4;
    localparam int NOISE_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int DATA_W     = 18;
    localparam int ORDER_W    = 3;
    localparam int FRAC_W     = 14;

    // Stream and register port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Coefficient bank
    localparam int NUM_COEFS  = 4;
    localparam int COEF_IDX_W = 2;
    localparam int TAP_W      = 3;

    // Accumulator: four Q8.28 taps plus the noise term fit comfortably
    localparam int ACC_W      = 40;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 40'sd8192;
    localparam logic signed [ACC_W-1:0] SAT_HI     = 40'sd131071;
    localparam logic signed [ACC_W-1:0] SAT_LO     = -40'sd131072;

    // Parameter defaults
    localparam int DEF_MAX_ORDER = 4;
    localparam int DEF_ELEMENTS  = 16;

    typedef enum logic [2:0] {
        REG_ORDER      = 3'd0,
        REG_GAIN       = 3'd1,
        REG_COEF_ONE   = 3'd2,
        REG_COEF_TWO   = 3'd3,
        REG_COEF_THREE = 3'd4,
        REG_COEF_FOUR  = 3'd5
    } arnf_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_TAP,
        ST_ROUND
    } arnf_state_t;

endpackage

// ----- rtl/autoregressive_noise_filter_core.sv -----
// ----------------------------------------------------------------------------
// autoregressive_noise_filter_core
// Element-wise all-pole autoregressive generator with a shared multiply unit.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the history memory to zero, one entry a
// cycle; s_tready stays low during the sweep while register writes are taken
// as usual. Thereafter each input item takes the sequencer through the
// preparation step, the tap step, which reads and multiplies ntaps taps, where
// ntaps = min(effective order, 4), and the rounding step. The result is loaded
// into the output register in the rounding step, and the next item can be
// taken in the cycle after that at the earliest. The sequence is set by the
// single 18x18 multiplier that serves the noise term and then every tap in
// turn, and by the registered read data of the history RAM.
// One item is worked on at a time; a new item is accepted while the previous
// result still waits on m_tready, and the sequencer only holds once it has a
// fresh result to load.
// Registers are written over APB at byte address 4*i: order_in_use, noise_gain,
// then the four coefficients; write them only while the block is idle.
// ----------------------------------------------------------------------------
module autoregressive_noise_filter_core #(
    parameter int MAX_ORDER = arnf_pkg::DEF_MAX_ORDER,
    parameter int ELEMENTS  = arnf_pkg::DEF_ELEMENTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [arnf_pkg::S_TDATA_W-1:0]  s_tdata,   // element[3:0], unit_noise[19:4]
    input  logic                            s_tlast,   // matrix_end
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [arnf_pkg::M_TDATA_W-1:0]  m_tdata,   // out_element[3:0], new_value[21:4]
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arnf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [arnf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [arnf_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    import arnf_pkg::*;

    // Derived sizes
    localparam int HIST_DEPTH = MAX_ORDER * ELEMENTS;
    localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CLR_W      = ADDR_W + 1;
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int EIDX_W     = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int ELEM_CNT   = 1 << ELEM_W;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [ORDER_W-1:0]       order_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [DATA_W-1:0] coef_reg [NUM_COEFS];
    logic                     cfg_wr;
    arnf_reg_t                cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = arnf_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_W'(1);
            gain_reg  <= '0;
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_ORDER:      order_reg   <= pwdata[ORDER_W-1:0];
                REG_GAIN:       gain_reg    <= pwdata[GAIN_W-1:0];
                REG_COEF_ONE:   coef_reg[0] <= signed'(pwdata[DATA_W-1:0]);
                REG_COEF_TWO:   coef_reg[1] <= signed'(pwdata[DATA_W-1:0]);
                REG_COEF_THREE: coef_reg[2] <= signed'(pwdata[DATA_W-1:0]);
                REG_COEF_FOUR:  coef_reg[3] <= signed'(pwdata[DATA_W-1:0]);
                default:        ; // drop writes beyond the register list
            endcase
        end
    end

    // Read back: unused addresses return zero
    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_ORDER:      prdata = APB_DATA_W'(order_reg);
            REG_GAIN:       prdata = APB_DATA_W'(gain_reg);
            REG_COEF_ONE:   prdata = APB_DATA_W'(unsigned'(coef_reg[0]));
            REG_COEF_TWO:   prdata = APB_DATA_W'(unsigned'(coef_reg[1]));
            REG_COEF_THREE: prdata = APB_DATA_W'(unsigned'(coef_reg[2]));
            REG_COEF_FOUR:  prdata = APB_DATA_W'(unsigned'(coef_reg[3]));
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Element index folded into the history range (constant table)
    // ------------------------------------------------------------------
    logic [EIDX_W-1:0] emod_tab [ELEM_CNT];

    for (genvar g = 0; g < ELEM_CNT; g++)
    begin : g_emod
        localparam int EMOD = g % ELEMENTS;
        assign emod_tab[g] = EIDX_W'(EMOD);
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    arnf_state_t              state_reg, state_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;
    logic [ORD_W-1:0]         ring_reg, ring_next;
    logic [TAP_W-1:0]         k_reg, k_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [COEF_IDX_W-1:0]    rd_k_reg, rd_k_next;
    logic                     prod_vld_reg, prod_vld_next;
    logic                     out_vld_reg, out_vld_next;

    logic [ELEM_W-1:0]        el_reg, el_next;
    logic [EIDX_W-1:0]        e_reg, e_next;
    logic signed [NOISE_W-1:0] noise_reg, noise_next;
    logic                     last_reg, last_next;
    logic [ORD_W-1:0]         n_reg, n_next;
    logic [ORD_W-1:0]         pos_reg, pos_next;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ELEM_W-1:0]        out_el_reg, out_el_next;
    logic [DATA_W-1:0]        out_val_reg, out_val_next;

    // History RAM port signals
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    // Shared multiplier
    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [2*DATA_W-1:0] mul_p;

    // Helper values
    logic [ORD_W-1:0]         n_eff;
    logic [ORD_W-1:0]         ring_mod;
    logic [TAP_W-1:0]         ntaps;
    logic [ORD_W:0]           slot_sum;
    logic [ORD_W-1:0]         slot;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_val;
    logic [DATA_W-1:0]        sat_val;
    logic [ORD_W-1:0]         pos_inc;

    function automatic logic [ADDR_W-1:0] hist_addr(input logic [ORD_W-1:0]  s,
                                                    input logic [EIDX_W-1:0] e);
        logic [ADDR_W:0] wide;
        begin
            wide = (ADDR_W + 1)'(s) * (ADDR_W + 1)'(ELEMENTS) + (ADDR_W + 1)'(e);
            return wide[ADDR_W-1:0];
        end
    endfunction

    // Effective order: zero acts as one, clamp to MAX_ORDER
    always_comb
    begin
        if (order_reg == '0)
        begin
            n_eff = ORD_W'(1);
        end
        else if (int'(order_reg) > MAX_ORDER)
        begin
            n_eff = ORD_W'(MAX_ORDER);
        end
        else
        begin
            n_eff = ORD_W'(order_reg);
        end
    end

    // Ring position folded into the current order (it may have been lowered)
    always_comb
    begin
        logic [ORD_W-1:0] r;
        r = ring_reg;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (r >= n_reg)
            begin
                r = r - n_reg;
            end
        end
        ring_mod = r;
    end

    // Taps in use and the history slot of tap k: (pos + n - 1 - k) mod n
    assign ntaps    = (int'(n_reg) > NUM_COEFS) ? TAP_W'(NUM_COEFS) : TAP_W'(n_reg);
    assign slot_sum = (ORD_W + 1)'(pos_reg) + (ORD_W + 1)'(n_reg)
                      - (ORD_W + 1)'(1) - (ORD_W + 1)'(k_reg);
    assign slot     = (slot_sum >= (ORD_W + 1)'(n_reg))
                      ? ORD_W'(slot_sum - (ORD_W + 1)'(n_reg))
                      : ORD_W'(slot_sum);

    // Ring advance, wrapping at the effective order
    assign pos_inc = ((ORD_W + 1)'(pos_reg) + (ORD_W + 1)'(1) >= (ORD_W + 1)'(n_reg))
                     ? '0 : ORD_W'(pos_reg + ORD_W'(1));

    // Round half up to Q.14 and saturate to 18 bits
    assign rnd_sum = acc_reg + ROUND_BIAS;
    assign rnd_val = rnd_sum >>> FRAC_W;
    assign sat_val = (rnd_val > SAT_HI) ? DATA_W'(SAT_HI) :
                     (rnd_val < SAT_LO) ? DATA_W'(SAT_LO) :
                     DATA_W'(rnd_val);

    // Shared multiplier: noise term in the preparation step, taps afterwards
    always_comb
    begin
        if (state_reg == ST_PREP)
        begin
            mul_a = signed'(DATA_W'(gain_reg));
            mul_b = DATA_W'(noise_reg);
        end
        else
        begin
            mul_a = coef_reg[rd_k_reg];
            mul_b = signed'(ram_rdata);
        end
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        ring_next     = ring_reg;
        k_next        = k_reg;
        rd_vld_next   = rd_vld_reg;
        rd_k_next     = rd_k_reg;
        prod_vld_next = prod_vld_reg;
        out_vld_next  = out_vld_reg;
        el_next       = el_reg;
        e_next        = e_reg;
        noise_next    = noise_reg;
        last_next     = last_reg;
        n_next        = n_reg;
        pos_next      = pos_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        out_el_next   = out_el_reg;
        out_val_next  = out_val_reg;

        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = hist_addr(pos_reg, e_reg);
        ram_wdata = sat_val;
        ram_raddr = hist_addr(slot, e_reg);

        // Result taken downstream
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the history to zero
                ram_we    = 1'b1;
                ram_waddr = clr_reg[ADDR_W-1:0];
                ram_wdata = '0;
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(HIST_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    el_next    = s_tdata[ELEM_W-1:0];
                    e_next     = emod_tab[s_tdata[ELEM_W-1:0]];
                    noise_next = signed'(s_tdata[ELEM_W +: NOISE_W]);
                    last_next  = s_tlast;
                    n_next     = n_eff;
                    state_next = ST_PREP;
                end
            end

            ST_PREP:
            begin
                // Fold the ring position and form the noise term (Q.26 to Q.28)
                pos_next      = ring_mod;
                prod_next     = ACC_W'(mul_p) <<< 2;
                prod_vld_next = 1'b1;
                acc_next      = '0;
                k_next        = '0;
                rd_vld_next   = 1'b0;
                state_next    = ST_TAP;
            end

            ST_TAP:
            begin
                // Issue the read of tap k
                if (k_reg < ntaps)
                begin
                    rd_vld_next = 1'b1;
                    rd_k_next   = k_reg[COEF_IDX_W-1:0];
                    k_next      = k_reg + TAP_W'(1);
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end

                // Multiply the tap whose history word has arrived
                if (rd_vld_reg)
                begin
                    prod_next     = ACC_W'(mul_p);
                    prod_vld_next = 1'b1;
                end
                else
                begin
                    prod_vld_next = 1'b0;
                end

                // Accumulate the previous product
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + prod_reg;
                end

                if ((k_reg >= ntaps) && !rd_vld_reg)
                begin
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                // Hold until the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    out_el_next  = el_reg;
                    out_val_next = sat_val;
                    ram_we       = 1'b1;
                    ring_next    = last_reg ? pos_inc : pos_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ring_reg     <= '0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            rd_k_reg     <= '0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            ring_reg     <= ring_next;
            k_reg        <= k_next;
            rd_vld_reg   <= rd_vld_next;
            rd_k_reg     <= rd_k_next;
            prod_vld_reg <= prod_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        el_reg      <= el_next;
        e_reg       <= e_next;
        noise_reg   <= noise_next;
        last_reg    <= last_next;
        n_reg       <= n_next;
        pos_reg     <= pos_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        out_el_reg  <= out_el_next;
        out_val_reg <= out_val_next;
    end

    // ------------------------------------------------------------------
    // History memory: MAX_ORDER slots of ELEMENTS words
    // ------------------------------------------------------------------
    arnf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output item
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'({out_val_reg, out_el_reg});

endmodule

// ----- rtl/arnf_ram.sv -----
// ----------------------------------------------------------------------------
// arnf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arnf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- verif/tb_autoregressive_noise_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_autoregressive_noise_filter_core
// Self-checking bench for the element-wise autoregressive noise filter.
// A directed table covers the register extremes, the effective-order limits,
// a ring position left outside a lowered order, the ignored register slots
// and the saturation bounds. Random matrix sweeps follow under three idling
// patterns. Every result item is checked against a built-in predictor of the filter or a fixed table value.
// ----------------------------------------------------------------------------
module tb_autoregressive_noise_filter_core;

    import arnf_pkg::*;

    localparam int HIST_ELEMS = DEF_ELEMENTS;
    localparam int HIST_SLOTS = DEF_MAX_ORDER;

    // Register slots past the last register: writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VALUE_TOP    = 18'h1FFFF;
    localparam logic signed [DATA_W-1:0] VALUE_BOTTOM = 18'h20000;

    // Cycles to let pass once the last result is out
    localparam int CFG_SETTLE = 12;
    localparam int END_SETTLE = 20;
    // Random part: items per idling pattern, items between register updates
    localparam int PHASE_ITEMS   = 633;
    localparam int RECONFIG_SPAN = 150;

    typedef enum logic {
        ROW_WRITE,
        ROW_ITEM
    } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [2:0]                 reg_idx;
        logic [31:0]                wdata;
        logic [ELEM_W-1:0]          elem;
        logic [NOISE_W-1:0]         noise;
        logic                       last;
        logic                       fixed;
        logic signed [DATA_W-1:0]   fixed_value;
    } stim_row_t;

    typedef struct {
        logic [ELEM_W-1:0]          elem;
        logic signed [DATA_W-1:0]   value;
    } ar_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // element[3:0], unit_noise[19:4]
    logic                    s_tlast;   // matrix_end
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;   // out_element[3:0], new_value[21:4]
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow of the filter: registers, per-element history and ring slot
    logic [ORDER_W-1:0]        order_reg;
    logic [GAIN_W-1:0]         gain_reg;
    logic signed [DATA_W-1:0]  coef_reg [NUM_COEFS];
    logic signed [DATA_W-1:0]  hist_mem [HIST_SLOTS*HIST_ELEMS];
    logic [1:0]                ring_slot;

    ar_result_t  expected_values [$];
    ar_result_t  oldest;
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    autoregressive_noise_filter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[autoregressive_noise_filter_core] ERROR");
        $finish;
    end

    // Receiver: stall at random at the rate of the current idling pattern
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_values.size() == 0)
            begin
                $error("result item with nothing expected: out_element %0d new_value %0d",
                       m_tdata[3:0], $signed(m_tdata[21:4]));
                mismatch_count++;
            end
            else
            begin
                oldest = expected_values.pop_front();
                if (m_tdata[3:0] !== oldest.elem)
                begin
                    $error("out_element: expected %0d, got %0d", oldest.elem, m_tdata[3:0]);
                    mismatch_count++;
                end
                if ($signed(m_tdata[21:4]) !== oldest.value)
                begin
                    $error("new_value: expected %0d, got %0d",
                           oldest.value, $signed(m_tdata[21:4]));
                    mismatch_count++;
                end
            end
        end
    end

    // Mirror a register write into the shadow; unknown slots change nothing
    function automatic void shadow_write(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_ORDER:      order_reg = data[ORDER_W-1:0];
            REG_GAIN:       gain_reg = data[GAIN_W-1:0];
            REG_COEF_ONE:   coef_reg[0] = data[DATA_W-1:0];
            REG_COEF_TWO:   coef_reg[1] = data[DATA_W-1:0];
            REG_COEF_THREE: coef_reg[2] = data[DATA_W-1:0];
            REG_COEF_FOUR:  coef_reg[3] = data[DATA_W-1:0];
            default:        ;
        endcase
    endfunction

    // Advance the process for one element and return its new value
    function automatic logic signed [DATA_W-1:0] next_process_value(
        input logic [ELEM_W-1:0]  elem,
        input logic [NOISE_W-1:0] noise,
        input logic               last
    );
        int unsigned n;
        int unsigned slot_now;
        int unsigned slot_k;
        int unsigned k;
        longint      acc;
        longint      val;
        n = order_reg;
        // Order zero acts as one, anything above the bank size as the bank size
        if (n < 1)
            n = 1;
        if (n > HIST_SLOTS)
            n = HIST_SLOTS;
        // A ring slot left over from a higher order wraps into the current one
        slot_now = ring_slot % n;
        acc = 0;
        for (k = 0; k < n && k < NUM_COEFS; k++)
        begin
            slot_k = (slot_now + n - 1 - k) % n;
            acc += longint'(coef_reg[k]) * longint'(hist_mem[slot_k*HIST_ELEMS + elem]);
        end
        // Noise term is Q6.26; bring it up to the Q.28 of the taps
        acc += longint'(gain_reg) * longint'($signed(noise)) * 4;
        val = (acc + 8192) >>> FRAC_W;
        if (val > longint'(VALUE_TOP))
            val = VALUE_TOP;
        if (val < longint'(VALUE_BOTTOM))
            val = VALUE_BOTTOM;
        hist_mem[slot_now*HIST_ELEMS + elem] = val[DATA_W-1:0];
        if (last)
            ring_slot = (slot_now + 1 >= n) ? 2'd0 : 2'(slot_now + 1);
        else
            ring_slot = 2'(slot_now);
        return val[DATA_W-1:0];
    endfunction

    function automatic stim_row_t write_row(input logic [2:0] idx, input logic [31:0] data);
        stim_row_t r;
        r = '{ROW_WRITE, idx, data, '0, '0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic stim_row_t item_row(
        input logic [ELEM_W-1:0]        elem,
        input logic [NOISE_W-1:0]       noise,
        input logic                     last,
        input logic                     fixed,
        input logic signed [DATA_W-1:0] value
    );
        stim_row_t r;
        r = '{ROW_ITEM, REG_ORDER, '0, elem, noise, last, fixed, value};
        return r;
    endfunction

    // Mostly triangular noise around zero, a quarter over the full range
    function automatic logic [NOISE_W-1:0] draw_noise();
        if ($urandom_range(0, 3) == 0)
            return NOISE_W'($urandom());
        return NOISE_W'(int'($urandom_range(0, 8192)) + int'($urandom_range(0, 8192)) - 8192);
    endfunction

    // Setup cycle, then access cycle; leave the bus idle after it
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_write(idx, data);
        @(posedge clk);
    endtask

    // Offer one item, holding it until accepted, and log what it must produce
    task automatic send_item(
        input logic [ELEM_W-1:0]        elem,
        input logic [NOISE_W-1:0]       noise,
        input logic                     last,
        input logic                     fixed,
        input logic signed [DATA_W-1:0] fixed_value
    );
        logic signed [DATA_W-1:0] predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-ELEM_W-NOISE_W){1'b0}}, noise, elem};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = next_process_value(elem, noise, last);
        expected_values.push_back('{elem, fixed ? fixed_value : predicted});
    endtask

    // Hold the sender until every result is out, then let the block settle
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Fresh register set: mostly stable small taps, now and then the extremes
    task automatic randomise_settings();
        logic [31:0] data;
        int          k;
        data = $urandom();
        data[ORDER_W-1:0] = ($urandom_range(0, 4) == 0) ? ORDER_W'($urandom_range(0, 7))
                                                       : ORDER_W'($urandom_range(1, 4));
        apb_write(REG_ORDER, data);
        data = $urandom();
        if ($urandom_range(0, 3) != 0)
            data[GAIN_W-1:0] = GAIN_W'($urandom_range(1024, 12000));
        apb_write(REG_GAIN, data);
        for (k = 0; k < NUM_COEFS; k++)
        begin
            data = $urandom();
            case ($urandom_range(0, 7))
                0:       data[DATA_W-1:0] = VALUE_TOP;
                1:       data[DATA_W-1:0] = VALUE_BOTTOM;
                2:       data[DATA_W-1:0] = '0;
                default: data[DATA_W-1:0] = DATA_W'(int'($urandom_range(0, 8000)) - 4000);
            endcase
            apb_write(3'(REG_COEF_ONE + k), data);
        end
        if ($urandom_range(0, 3) == 0)
            apb_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    endtask

    // Mostly matrix sweeps in element order, whole or cut short; the rest stray items
    task automatic send_random_burst(inout int sent);
        int span;
        int e;
        if ($urandom_range(0, 99) < 85)
        begin
            span = ($urandom_range(0, 2) == 0) ? HIST_ELEMS : $urandom_range(1, HIST_ELEMS);
            for (e = 0; e < span; e++)
                send_item(ELEM_W'(e), draw_noise(), e == span - 1, 1'b0, '0);
            sent += span;
        end
        else
        begin
            send_item(ELEM_W'($urandom_range(0, HIST_ELEMS - 1)), draw_noise(),
                      1'($urandom_range(0, 1)), 1'b0, '0);
            sent += 1;
        end
    endtask

    initial
    begin
        int i;
        int phase;
        int phase_sent;
        int since_cfg;
        int burst_start;
        logic prev_write;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        order_reg = 3'd1;
        gain_reg  = '0;
        ring_slot = '0;
        for (i = 0; i < NUM_COEFS; i++)
            coef_reg[i] = '0;
        for (i = 0; i < HIST_SLOTS*HIST_ELEMS; i++)
            hist_mem[i] = '0;

        // Reset values: no taps, no noise, so the first items come out as zero
        directed_rows.push_back(item_row(4'd0, 16'h7FFF, 1'b0, 1'b1, '0));
        directed_rows.push_back(item_row(4'd15, 16'h8000, 1'b1, 1'b1, '0));
        // Full gain on full-scale noise saturates both ways
        directed_rows.push_back(write_row(REG_GAIN, 32'h0000_FFFF));
        directed_rows.push_back(item_row(4'd5, 16'h7FFF, 1'b0, 1'b1, VALUE_TOP));
        directed_rows.push_back(item_row(4'd10, 16'h8000, 1'b1, 1'b1, VALUE_BOTTOM));
        // Unity gain on unit noise gives exactly one
        directed_rows.push_back(write_row(REG_GAIN, 32'd16384));
        directed_rows.push_back(item_row(4'd1, 16'h1000, 1'b0, 1'b1, 18'sd16384));
        // Mixed taps at order four, one at the bottom extreme; upper data bits must be dropped
        directed_rows.push_back(write_row(REG_COEF_ONE, 32'hFFFE_FFFF));
        directed_rows.push_back(write_row(REG_COEF_TWO, 32'h0002_0000));
        directed_rows.push_back(write_row(REG_COEF_THREE, 32'h0000_2000));
        directed_rows.push_back(write_row(REG_COEF_FOUR, 32'h0003_E000));
        directed_rows.push_back(write_row(REG_ORDER, 32'hFFFF_FFFC));
        directed_rows.push_back(item_row(4'd1, 16'h1000, 1'b1, 1'b0, '0));
        directed_rows.push_back(item_row(4'd1, 16'hF000, 1'b1, 1'b0, '0));
        directed_rows.push_back(item_row(4'd1, 16'h0800, 1'b1, 1'b0, '0));
        // Ring now stands at slot three: lower the order beneath it
        directed_rows.push_back(write_row(REG_ORDER, 32'd2));
        directed_rows.push_back(item_row(4'd1, 16'h1000, 1'b1, 1'b0, '0));
        directed_rows.push_back(item_row(4'd2, 16'h7FFF, 1'b0, 1'b0, '0));
        // Order zero acts as one
        directed_rows.push_back(write_row(REG_ORDER, 32'd0));
        directed_rows.push_back(item_row(4'd1, 16'h0001, 1'b1, 1'b0, '0));
        // Orders above the bank act as four
        directed_rows.push_back(write_row(REG_ORDER, 32'd7));
        directed_rows.push_back(item_row(4'd1, 16'hFFFF, 1'b1, 1'b0, '0));
        directed_rows.push_back(item_row(4'd15, 16'h8000, 1'b0, 1'b0, '0));
        directed_rows.push_back(write_row(REG_ORDER, 32'd5));
        directed_rows.push_back(item_row(4'd1, 16'h1234, 1'b1, 1'b0, '0));
        // Writes past the register bank leave everything as it was
        directed_rows.push_back(write_row(REG_SPARE_LO, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(REG_SPARE_HI, 32'h0000_0000));
        directed_rows.push_back(item_row(4'd1, 16'h4000, 1'b1, 1'b0, '0));
        // Pure unit feedback at order one with the noise shut off
        directed_rows.push_back(write_row(REG_GAIN, 32'd0));
        directed_rows.push_back(write_row(REG_COEF_ONE, 32'h0000_4000));
        directed_rows.push_back(write_row(REG_ORDER, 32'd1));
        directed_rows.push_back(item_row(4'd1, 16'h0000, 1'b1, 1'b0, '0));
        directed_rows.push_back(item_row(4'd5, 16'h0000, 1'b0, 1'b0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, under the first idling pattern
        src_idle_pct  = 9;
        snk_stall_pct = 52;
        prev_write = 1'b1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                // Hold off register writes until the block has gone quiet
                if (!prev_write)
                    drain_results(CFG_SETTLE);
                apb_write(directed_rows[i].reg_idx, directed_rows[i].wdata);
                prev_write = 1'b1;
            end
            else
            begin
                send_item(directed_rows[i].elem, directed_rows[i].noise,
                          directed_rows[i].last, directed_rows[i].fixed,
                          directed_rows[i].fixed_value);
                prev_write = 1'b0;
            end
        end

        // Random sweeps: sender light / receiver heavy, then swapped, then none
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 52 : 0;
            snk_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 9 : 0;
            phase_sent = 0;
            since_cfg  = RECONFIG_SPAN;
            while (phase_sent < PHASE_ITEMS)
            begin
                if (since_cfg >= RECONFIG_SPAN)
                begin
                    drain_results(CFG_SETTLE);
                    randomise_settings();
                    since_cfg = 0;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    // Let the pipeline run dry before the next sweep
                    drain_results(1);
                end
                burst_start = since_cfg;
                send_random_burst(since_cfg);
                phase_sent += since_cfg - burst_start;
            end
        end

        drain_results(END_SETTLE);
        if (mismatch_count == 0)
            $display("[autoregressive_noise_filter_core] OK");
        else
            $display("[autoregressive_noise_filter_core] ERROR");
        $finish;
    end

endmodule
